>>> rtl/hrsp_pkg.sv
package hrsp_pkg;

   localparam int LengthBitsDefault = 32;

   typedef enum logic [14:0] {
      PH_PROTO   = 15'h0001,
      PH_STATUS  = 15'h0002,
      PH_REASON  = 15'h0004,
      PH_LINE    = 15'h0008,
      PH_LINE_CR = 15'h0010,
      PH_NAME    = 15'h0020,
      PH_VALUE   = 15'h0040,
      PH_BODY    = 15'h0080,
      PH_CSIZE   = 15'h0100,
      PH_CEXT    = 15'h0200,
      PH_CDATA   = 15'h0400,
      PH_CCR     = 15'h0800,
      PH_CLF     = 15'h1000,
      PH_TRAILER = 15'h2000,
      PH_HALT    = 15'h4000
   } phase_type;

   typedef enum logic [1:0] {
      FS_NONE = 2'd0,
      FS_CL   = 2'd1,
      FS_TE   = 2'd2,
      FS_CE   = 2'd3
   } field_type;

   localparam logic [2:0] EV_NONE  = 3'd0;
   localparam logic [2:0] EV_BODY  = 3'd1;
   localparam logic [2:0] EV_HDR   = 3'd2;
   localparam logic [2:0] EV_DONE  = 3'd3;
   localparam logic [2:0] EV_ERROR = 3'd4;

   localparam logic [3:0] ERR_NONE     = 4'd0;
   localparam logic [3:0] ERR_PROTOCOL = 4'd8;
   localparam logic [3:0] ERR_VERSION  = 4'd9;
   localparam logic [3:0] ERR_HEADER   = 4'd10;
   localparam logic [3:0] ERR_CHUNK    = 4'd11;
   localparam logic [3:0] ERR_TE       = 4'd12;

   localparam logic [7:0] CH_CR = 8'd13;
   localparam logic [7:0] CH_LF = 8'd10;

   typedef struct packed {
      logic [2:0] event_res;
      logic [7:0] body_byte;
   } beat_type;

   function automatic logic [7:0] proto_char(input logic [4:0] i);
      case (i)
         5'd0: proto_char = "H";
         5'd1: proto_char = "T";
         5'd2: proto_char = "T";
         5'd3: proto_char = "P";
         5'd4: proto_char = "/";
         5'd5: proto_char = "1";
         5'd6: proto_char = ".";
         5'd7: proto_char = "1";
         default: proto_char = " ";
      endcase
   endfunction

   function automatic logic [7:0] name_char(input logic [1:0] n, input logic [4:0] i);
      logic [8*17-1:0] s;
      s = (n == 2'd0) ? {"content-length", 24'd0} :
          (n == 2'd1) ? "transfer-encoding" : {"content-encoding", 8'd0};
      name_char = s[8*(16-i) +: 8];
   endfunction

   function automatic logic [4:0] name_len(input logic [1:0] n);
      name_len = (n == 2'd0) ? 5'd14 : (n == 2'd1) ? 5'd17 : 5'd16;
   endfunction

   function automatic logic [7:0] val_char(input logic [1:0] n, input logic [4:0] i);
      logic [8*8-1:0] s;
      case (n)
         2'd0: s = "identity";
         2'd1: s = {"chunked", 8'd0};
         2'd2: s = {"gzip", 32'd0};
         default: s = {"deflate", 8'd0};
      endcase
      val_char = s[8*(7-i[2:0]) +: 8];
   endfunction

   function automatic logic [4:0] val_len(input logic [1:0] n);
      case (n)
         2'd0: val_len = 5'd8;
         2'd1: val_len = 5'd7;
         2'd2: val_len = 5'd4;
         default: val_len = 5'd7;
      endcase
   endfunction

   function automatic logic is_ws(input logic [7:0] b);
      is_ws = (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] b);
      to_lower = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
   endfunction

   function automatic logic [4:0] hex_val(input logic [7:0] b);
      if (b >= "0" && b <= "9") hex_val = {1'b0, b[3:0]};
      else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F"))
         hex_val = {1'b0, b[3:0] + 4'd9};
      else hex_val = 5'h10;
   endfunction

   function automatic logic [3:0] classify(input logic [9:0] s);
      if (s >= 10'd500) classify = 4'd1;
      else if (s >= 10'd400)
         classify = (s == 10'd401) ? 4'd3 : (s == 10'd403) ? 4'd4 :
                    (s == 10'd404) ? 4'd5 : 4'd2;
      else if (s >= 10'd300) classify = (s == 10'd304) ? 4'd6 : 4'd7;
      else if (s >= 10'd200) classify = 4'd0;
      else classify = 4'd1;
   endfunction

endpackage

>>> rtl/hrsp_core.sv
module hrsp_core
   import hrsp_pkg::*;
#(
   parameter int LENGTH_BITS = LengthBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic [7:0]  b,
   input  logic        expect_body,
   output beat_type    beat,
   output logic [9:0]  status_code,
   output logic [3:0]  result_code,
   output logic [1:0]  transfer_kind,
   output logic [1:0]  content_kind,
   output logic [31:0] content_length
);

   localparam logic [LENGTH_BITS-1:0] LenMax = '1;
   localparam logic [LENGTH_BITS-1:0] HexLim = LenMax >> 4;

   phase_type              phase_ff, phase_in;
   logic [4:0]             pos_ff, pos_in;
   logic [9:0]             stat_ff, stat_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in, rem_ff, rem_in;
   logic [2:0]             ncand_ff, ncand_in;
   logic [3:0]             vcand_ff, vcand_in;
   field_type              fsel_ff, fsel_in;
   logic [1:0]             lep_ff, lep_in;
   logic                   dig_ff, dig_in;
   logic [1:0]             tm_ff, tm_in, cm_ff, cm_in;
   logic [3:0]             err_ff, err_in;
   logic                   tst_ff, tst_in, sp_ff, sp_in, raw_ff, raw_in;
   logic [2:0]             ev;

   logic [LENGTH_BITS+3:0] len_x10;
   logic [13:0]            stat_x10;
   logic [4:0]             hv;
   logic [7:0]             lc;
   logic                   fire_ws;

   always_comb begin
      logic [7:0] vb;
      logic       feed;
      phase_in = phase_ff; pos_in = pos_ff; stat_in = stat_ff; len_in = len_ff;
      rem_in = rem_ff; ncand_in = ncand_ff; vcand_in = vcand_ff; fsel_in = fsel_ff;
      lep_in = lep_ff; dig_in = dig_ff; tm_in = tm_ff; cm_in = cm_ff; err_in = err_ff;
      tst_in = tst_ff; sp_in = sp_ff; raw_in = raw_ff; ev = EV_NONE;
      vb = b; feed = 1'b0;
      lc = to_lower(b);
      hv = hex_val(b);
      fire_ws = is_ws(b);
      stat_x10 = {4'd0, stat_ff} * 14'd10 + {10'd0, b[3:0]};
      len_x10 = {4'd0, len_ff} * 10 + {{(LENGTH_BITS){1'b0}}, b[3:0]};
      unique case (phase_ff)
         PH_PROTO: begin
            if (pos_ff < 5'd9 && b == proto_char(pos_ff)) begin
               pos_in = pos_ff + 5'd1;
               if (pos_ff == 5'd8) begin
                  phase_in = PH_STATUS; pos_in = '0; stat_in = '0; dig_in = 1'b0;
               end
            end else begin
               ev = EV_ERROR; phase_in = PH_HALT;
               if (err_ff == ERR_NONE)
                  err_in = (pos_ff < 5'd4) ? ERR_PROTOCOL :
                           (pos_ff < 5'd8) ? ERR_VERSION : ERR_HEADER;
            end
         end
         PH_STATUS: begin
            if (b >= "0" && b <= "9") begin
               stat_in = (stat_x10 > 14'd999) ? 10'd999 : stat_x10[9:0];
               dig_in = 1'b1;
            end else if (!dig_ff) begin
               ev = EV_ERROR; phase_in = PH_HALT;
               if (err_ff == ERR_NONE) err_in = ERR_HEADER;
            end else begin
               phase_in = PH_REASON;
               lep_in = (b == CH_CR) ? 2'd1 : 2'd0;
            end
         end
         PH_REASON, PH_CEXT: begin
            if (lep_ff == 2'd1 && b == CH_LF) begin
               lep_in = 2'd0;
               if (phase_ff == PH_CEXT) phase_in = PH_CDATA;
               else begin
                  phase_in = PH_LINE; ncand_in = 3'b111; fsel_in = FS_NONE;
                  pos_in = '0; tst_in = 1'b0; sp_in = 1'b0; raw_in = 1'b0;
               end
            end else lep_in = (b == CH_CR) ? 2'd1 : 2'd0;
         end
         PH_LINE, PH_LINE_CR, PH_NAME: begin
            if (phase_ff == PH_LINE && b == CH_CR) phase_in = PH_LINE_CR;
            else if (phase_ff == PH_LINE_CR && b == CH_LF) begin
               if (!expect_body) begin phase_in = PH_HALT; ev = EV_DONE; end
               else if (tm_ff == 2'd2) begin
                  ev = EV_ERROR; phase_in = PH_HALT;
                  if (err_ff == ERR_NONE) err_in = ERR_TE;
               end else if (tm_ff == 2'd1) begin
                  phase_in = PH_CSIZE; rem_in = '0; dig_in = 1'b0; ev = EV_HDR;
               end else begin
                  rem_in = len_ff;
                  if (len_ff == '0) begin phase_in = PH_HALT; ev = EV_DONE; end
                  else begin phase_in = PH_BODY; ev = EV_HDR; end
               end
            end else begin
               logic rne;
               rne = raw_ff || (phase_ff == PH_LINE_CR);
               phase_in = PH_NAME;
               if (b == ":") begin
                  if (!rne) begin
                     ev = EV_ERROR; phase_in = PH_HALT;
                     if (err_ff == ERR_NONE) err_in = ERR_HEADER;
                  end else begin
                     if (ncand_ff[0] && pos_ff == name_len(2'd0)) fsel_in = FS_CL;
                     else if (ncand_ff[1] && pos_ff == name_len(2'd1)) fsel_in = FS_TE;
                     else if (ncand_ff[2] && pos_ff == name_len(2'd2)) fsel_in = FS_CE;
                     else fsel_in = FS_NONE;
                     if (fsel_in == FS_CL) len_in = '0;
                     vcand_in = 4'b1111; pos_in = '0; tst_in = 1'b0; sp_in = 1'b0;
                     raw_in = 1'b0; lep_in = 2'd0; phase_in = PH_VALUE;
                  end
               end else begin
                  raw_in = 1'b1;
                  if (fire_ws) begin
                     if (tst_ff) sp_in = 1'b1;
                  end else begin
                     logic [2:0] c;
                     c = sp_ff ? 3'b000 : ncand_ff;
                     tst_in = 1'b1;
                     for (int i = 0; i < 3; i++)
                        if (c[i] && (pos_ff >= name_len(2'(i)) ||
                                     name_char(2'(i), pos_ff) != lc))
                           c[i] = 1'b0;
                     ncand_in = c;
                     if (pos_ff < 5'd31) pos_in = pos_ff + 5'd1;
                  end
               end
            end
         end
         PH_VALUE: begin
            if (lep_ff == 2'd1 && b == CH_LF) begin
               if (fsel_ff == FS_TE) begin
                  if (!raw_ff || (vcand_ff[0] && pos_ff == val_len(2'd0))) tm_in = 2'd0;
                  else if (vcand_ff[1] && pos_ff == val_len(2'd1)) tm_in = 2'd1;
                  else tm_in = 2'd2;
               end else if (fsel_ff == FS_CE) begin
                  if (!raw_ff || (vcand_ff[0] && pos_ff == val_len(2'd0))) cm_in = 2'd0;
                  else if (vcand_ff[2] && pos_ff == val_len(2'd2)) cm_in = 2'd1;
                  else if (vcand_ff[3] && pos_ff == val_len(2'd3)) cm_in = 2'd2;
                  else cm_in = 2'd3;
               end
               phase_in = PH_LINE; ncand_in = 3'b111; fsel_in = FS_NONE;
               pos_in = '0; tst_in = 1'b0; sp_in = 1'b0; raw_in = 1'b0; lep_in = 2'd0;
            end else if (lep_ff == 2'd1 && b != CH_CR) begin
               // pending CR and this byte are both value bytes: CR is whitespace
               // and only flags a space, so fold it in before the byte
               lep_in = 2'd0; feed = 1'b1;
            end else if (b == CH_CR) begin
               lep_in = 2'd1;
               if (lep_ff == 2'd1) begin vb = CH_CR; feed = 1'b1; end
            end else feed = 1'b1;
            if (feed) begin
               logic pend_cr, sp_v, ts_v;
               pend_cr = (lep_ff == 2'd1) && (vb != CH_CR || b == CH_CR);
               pend_cr = (lep_ff == 2'd1) && b != CH_CR;
               raw_in = 1'b1;
               ts_v = tst_ff; sp_v = sp_ff;
               if (pend_cr && fsel_ff != FS_CL && tst_ff) sp_v = 1'b1;
               if (fsel_ff == FS_CL) begin
                  // pending CR: nonblank leading CR or digit-terminator
                  if (pend_cr && tst_ff) fsel_in = FS_NONE;
                  else if (pend_cr || !(!tst_ff && is_ws(vb)) || tst_ff) begin
                     if (!tst_ff && is_ws(vb) && !pend_cr) begin
                     end else if (pend_cr && !tst_ff && is_ws(vb)) begin
                     end else begin
                        tst_in = 1'b1;
                        if (vb >= "0" && vb <= "9") begin
                           if (len_x10[LENGTH_BITS+3:LENGTH_BITS] != 4'd0)
                              len_in = LenMax;
                           else len_in = len_x10[LENGTH_BITS-1:0];
                        end else fsel_in = FS_NONE;
                     end
                  end
               end else if (fsel_ff == FS_TE || fsel_ff == FS_CE) begin
                  if (is_ws(vb)) begin
                     if (ts_v) sp_in = 1'b1; else sp_in = sp_v;
                  end else begin
                     logic [3:0] c;
                     c = sp_v ? 4'b0000 : vcand_ff;
                     tst_in = 1'b1; sp_in = sp_v;
                     for (int i = 0; i < 4; i++)
                        if (c[i] && (pos_ff >= val_len(2'(i)) ||
                                     val_char(2'(i), pos_ff) != to_lower(vb)))
                           c[i] = 1'b0;
                     vcand_in = c;
                     if (pos_ff < 5'd31) pos_in = pos_ff + 5'd1;
                  end
               end
            end
         end
         PH_BODY, PH_CDATA: begin
            ev = EV_BODY;
            if (rem_ff != '0) rem_in = rem_ff - 1'b1;
            if (rem_ff <= 1) phase_in = (phase_ff == PH_BODY) ? PH_HALT : PH_CCR;
         end
         PH_CSIZE: begin
            if (!hv[4]) begin
               if (rem_ff > HexLim) begin
                  ev = EV_ERROR; phase_in = PH_HALT;
                  if (err_ff == ERR_NONE) err_in = ERR_CHUNK;
               end else begin
                  rem_in = {rem_ff[LENGTH_BITS-5:0], hv[3:0]}; dig_in = 1'b1;
               end
            end else if (!dig_ff) begin
               ev = EV_ERROR; phase_in = PH_HALT;
               if (err_ff == ERR_NONE) err_in = ERR_CHUNK;
            end else begin
               lep_in = (b == CH_CR) ? 2'd1 : 2'd0;
               phase_in = (rem_ff == '0) ? PH_TRAILER : PH_CEXT;
            end
         end
         PH_CCR, PH_CLF: begin
            if (phase_ff == PH_CCR && b == CH_CR) phase_in = PH_CLF;
            else if (phase_ff == PH_CLF && b == CH_LF) begin
               phase_in = PH_CSIZE; rem_in = '0; dig_in = 1'b0;
            end else begin
               ev = EV_ERROR; phase_in = PH_HALT;
               if (err_ff == ERR_NONE) err_in = ERR_CHUNK;
            end
         end
         PH_TRAILER: begin
            if (b == CH_CR) lep_in = (lep_ff == 2'd2) ? 2'd3 : 2'd1;
            else if (b == CH_LF && lep_ff == 2'd1) lep_in = 2'd2;
            else if (b == CH_LF && lep_ff == 2'd3) begin
               lep_in = 2'd0; phase_in = PH_HALT; ev = EV_DONE;
            end else lep_in = 2'd0;
         end
         default: phase_in = PH_HALT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PROTO; pos_ff <= '0; stat_ff <= '0; len_ff <= '0; rem_ff <= '0;
         ncand_ff <= 3'b111; vcand_ff <= 4'b1111; fsel_ff <= FS_NONE; lep_ff <= '0;
         dig_ff <= 1'b0; tm_ff <= '0; cm_ff <= '0; err_ff <= ERR_NONE;
         tst_ff <= 1'b0; sp_ff <= 1'b0; raw_ff <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in; pos_ff <= pos_in; stat_ff <= stat_in; len_ff <= len_in;
         rem_ff <= rem_in; ncand_ff <= ncand_in; vcand_ff <= vcand_in; fsel_ff <= fsel_in;
         lep_ff <= lep_in; dig_ff <= dig_in; tm_ff <= tm_in; cm_ff <= cm_in;
         err_ff <= err_in; tst_ff <= tst_in; sp_ff <= sp_in; raw_ff <= raw_in;
      end
   end

   assign beat.event_res  = ev;
   assign beat.body_byte  = (ev == EV_BODY) ? b : 8'd0;
   assign status_code     = stat_in;
   assign result_code     = (err_in != ERR_NONE) ? err_in : classify(stat_in);
   assign transfer_kind   = tm_in;
   assign content_kind    = cm_in;
   assign content_length  = 32'(len_in);

   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == PH_HALT |-> ev == EV_NONE)
      else $error("event after halt");
   a_err_halts: assert property (@(posedge clock) disable iff (reset)
      step && ev == EV_ERROR |=> phase_ff == PH_HALT && err_ff != ERR_NONE)
      else $error("error without halt");
   a_err_keep: assert property (@(posedge clock) disable iff (reset)
      $past(err_ff) != ERR_NONE && !$past(reset) |-> $stable(err_ff))
      else $error("sticky error changed");

endmodule

>>> rtl/http_response_stream_parser.sv
// Each accepted byte has its result beat loaded into the output register on the edge
// that accepts it. Throughput: one byte per cycle while the output register is empty
// or rsp_ready is high; the output register frees on the same edge it is taken.
// Reset: synchronous, active high; parser returns to status line start, no errors,
// expect_body set to 1, output register empty.
module http_response_stream_parser
   import hrsp_pkg::*;
#(
   parameter int LENGTH_BITS = LengthBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_res,
   output logic [7:0]  rsp_body_byte,
   output logic [9:0]  rsp_status_code,
   output logic [3:0]  rsp_result_code,
   output logic [1:0]  rsp_transfer_kind,
   output logic [1:0]  rsp_content_kind,
   output logic [31:0] rsp_content_length,
   input  logic        csr_write,
   input  logic        csr_wdata
);

   logic        expect_ff;
   logic        valid_ff;
   logic        step;
   beat_type    beat;
   logic [9:0]  sc;
   logic [3:0]  rc;
   logic [1:0]  tk, ck;
   logic [31:0] cl;

   assign req_ready = !valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;

   hrsp_core #(.LENGTH_BITS(LENGTH_BITS)) u_core (
      .clock, .reset, .step, .b(req_rx_byte), .expect_body(expect_ff),
      .beat, .status_code(sc), .result_code(rc), .transfer_kind(tk),
      .content_kind(ck), .content_length(cl)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_ff <= 1'b1;
         valid_ff  <= 1'b0;
      end else begin
         if (csr_write) expect_ff <= csr_wdata;
         if (req_ready) valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_event_res      <= beat.event_res;
         rsp_body_byte      <= beat.body_byte;
         rsp_status_code    <= sc;
         rsp_result_code    <= rc;
         rsp_transfer_kind  <= tk;
         rsp_content_kind   <= ck;
         rsp_content_length <= cl;
      end
   end

   assign rsp_valid = valid_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_res))
      else $error("beat dropped");

endmodule
